[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/exifo_pkg.sv]
// ----------------------------------------------------------------------------
// exifo_pkg
// Types, constants and byte-order helpers for the Exif orientation parser.
// ----------------------------------------------------------------------------
package exifo_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [7:0]  marker_code;
		logic [15:0] segment_length;
		logic        new_image;
	} exifo_item_t;

	typedef struct packed {
		logic [3:0] orientation;
		logic       segment_was_exif;
	} exifo_result_t;

	// parse phases
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_IDENT  = 4'd1;
	localparam logic [3:0] PH_SEARCH = 4'd2;
	localparam logic [3:0] PH_OFFSET = 4'd3;
	localparam logic [3:0] PH_COUNT  = 4'd4;
	localparam logic [3:0] PH_ENTRY  = 4'd5;
	localparam logic [3:0] PH_ORIENT = 4'd6;
	localparam logic [3:0] PH_DONE   = 4'd7;
	localparam logic [3:0] PH_SKIP   = 4'd8;

	localparam logic [15:0] MAX_SEGMENT_BYTES    = 16'hFFFF;
	localparam logic [15:0] HEADER_SEARCH_WINDOW = 16'd16;
	localparam logic [15:0] POS_MAX              = 16'hFFFF;
	localparam logic [15:0] MIN_EXIF_LEN         = 16'd32;
	localparam logic [3:0]  ENTRY_BYTES          = 4'd12;
	localparam logic [3:0]  ORIENT_LAST_OFFSET   = 4'd9;
	localparam logic [7:0]  APP1_CODE            = 8'd225;
	localparam logic [15:0] ORIENT_TAG           = 16'h0112;
	localparam logic [15:0] SHORT_TYPE           = 16'd3;
	localparam logic [15:0] MAX_ORIENT           = 16'd8;
	localparam logic [31:0] LE_HEADER            = 32'h4949_2A00;
	localparam logic [31:0] BE_HEADER            = 32'h4D4D_002A;

	// "Exif\0\0"
	function automatic logic [7:0] ident_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h45;
			3'd1:    r = 8'h78;
			3'd2:    r = 8'h69;
			3'd3:    r = 8'h66;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] order16(input logic [15:0] v, input logic be);
		return be ? v : {v[7:0], v[15:8]};
	endfunction

	function automatic logic [31:0] order32(input logic [31:0] v, input logic be);
		return be ? v : {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

[rtl/core/exifo_if.sv]
// ----------------------------------------------------------------------------
// exifo_if
// Valid/ready channels: segment bytes in, orientation results out.
// ----------------------------------------------------------------------------
interface exifo_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        last_byte;
	logic [7:0]  marker_code;
	logic [15:0] segment_length;
	logic        new_image;

	modport source (
		output valid, data_byte, first_byte, last_byte, marker_code, segment_length,
			new_image,
		input  ready
	);
	modport sink (
		input  valid, data_byte, first_byte, last_byte, marker_code, segment_length,
			new_image,
		output ready
	);
endinterface

interface exifo_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] orientation;
	logic       segment_was_exif;

	modport source (
		output valid, orientation, segment_was_exif,
		input  ready
	);
	modport sink (
		input  valid, orientation, segment_was_exif,
		output ready
	);
endinterface

[rtl/core/exifo_in_stage.sv]
// ----------------------------------------------------------------------------
// exifo_in_stage
// Input register: holds one word until the parser takes it.
// ----------------------------------------------------------------------------
module exifo_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	exifo_in_if.sink              bytes,
	input  logic                  take,
	output logic                  item_valid_s1,
	output exifo_pkg::exifo_item_t item_s1
);
	import exifo_pkg::*;

	logic accept;

	assign bytes.ready = !item_valid_s1 || take;
	assign accept      = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (take) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{data_byte:      bytes.data_byte,
			             first_byte:     bytes.first_byte,
			             last_byte:      bytes.last_byte,
			             marker_code:    bytes.marker_code,
			             segment_length: bytes.segment_length,
			             new_image:      bytes.new_image};
		end
	end

endmodule

[rtl/core/exifo_parser.sv]
// ----------------------------------------------------------------------------
// exifo_parser
// Per-byte segment parser: Exif ident, TIFF header search, IFD0 walk and
// orientation entry decode. One byte is consumed per take.
// ----------------------------------------------------------------------------
module exifo_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid_s1,
	input  exifo_pkg::exifo_item_t  item_s1,
	input  logic                    slot_free,
	output logic                    take,
	output logic                    res_valid,
	output exifo_pkg::exifo_result_t res
);
	import exifo_pkg::*;

	// registered parse state
	logic [15:0] pos_q, len_q, tags_q;
	logic [31:0] win_q;
	logic [3:0]  phase_q, hdr_q, eo_q, sres_q, held_q;
	logic        be_q;
	logic [16:0] ifd_q;
	logic [55:0] ef_q;

	// state as seen by this byte (after a segment start)
	logic [15:0] pos_c, len_c, tags_c;
	logic [31:0] win_c;
	logic [3:0]  phase_c, hdr_c, eo_c, sres_c, held_c;
	logic        be_c;
	logic [16:0] ifd_c;
	logic [55:0] ef_c;

	// next state
	logic [15:0] pos_n, tags_n;
	logic [31:0] win_n;
	logic [3:0]  phase_n, hdr_n, eo_n, sres_n, held_n;
	logic        be_n;
	logic [16:0] ifd_n;
	logic [55:0] ef_n;

	logic        open_c, in_len, produces, exif, upd;
	logic [7:0]  b;
	logic [15:0] srch_i, cnt_n, tag_c, typ, val;
	logic [31:0] off, cnt32;
	logic [32:0] start_w;
	logic [19:0] n12;
	logic [3:0]  eo_inc;
	logic [15:0] tags_dec;
	logic [63:0] full;

	assign b = item_s1.data_byte;

	always_comb begin
		if (item_s1.first_byte) begin
			pos_c   = '0;
			len_c   = (item_s1.segment_length > MAX_SEGMENT_BYTES) ?
			          MAX_SEGMENT_BYTES : item_s1.segment_length;
			win_c   = '0;
			be_c    = 1'b0;
			hdr_c   = '0;
			ifd_c   = '0;
			tags_c  = '0;
			eo_c    = '0;
			ef_c    = '0;
			sres_c  = '0;
			phase_c = (item_s1.marker_code == APP1_CODE) ? PH_IDENT : PH_SKIP;
		end else begin
			pos_c   = pos_q;
			len_c   = len_q;
			win_c   = win_q;
			be_c    = be_q;
			hdr_c   = hdr_q;
			ifd_c   = ifd_q;
			tags_c  = tags_q;
			eo_c    = eo_q;
			ef_c    = ef_q;
			sres_c  = sres_q;
			phase_c = phase_q;
		end
		held_c = (item_s1.first_byte && item_s1.new_image) ? 4'd0 : held_q;
		open_c = (phase_c != PH_IDLE);

		in_len  = (pos_c < len_c);
		win_n   = in_len ? {win_c[23:0], b} : win_c;
		srch_i  = pos_c - 16'd3;
		off     = order32(win_n, be_c);
		start_w = 33'(hdr_c) + 33'(off);
		cnt_n   = order16(win_n[15:0], be_c);
		n12     = 20'({cnt_n, 3'b000}) + 20'({cnt_n, 2'b00});
		tag_c   = order16(win_n[15:0], be_c);
		eo_inc  = eo_c + 4'd1;
		tags_dec = tags_c - 16'd1;
		full    = {ef_c, b};
		typ     = order16(full[63:48], be_c);
		cnt32   = order32(full[47:16], be_c);
		val     = order16(full[15:0], be_c);

		phase_n = phase_c;
		be_n    = be_c;
		hdr_n   = hdr_c;
		ifd_n   = ifd_c;
		tags_n  = tags_c;
		eo_n    = eo_c;
		ef_n    = ef_c;
		sres_n  = sres_c;

		if (in_len) begin
			unique case (phase_c)
				PH_IDENT: begin
					if (pos_c >= 16'd6 || b != ident_byte(pos_c[2:0])) begin
						phase_n = PH_SKIP;
					end else if (pos_c == 16'd5) begin
						phase_n = (len_c < MIN_EXIF_LEN) ? PH_DONE : PH_SEARCH;
					end
				end
				PH_SEARCH: begin
					if (pos_c >= 16'd3) begin
						if (srch_i >= HEADER_SEARCH_WINDOW) begin
							phase_n = PH_DONE;
						end else if (win_n == LE_HEADER || win_n == BE_HEADER) begin
							be_n    = (win_n == BE_HEADER);
							hdr_n   = srch_i[3:0];
							phase_n = PH_OFFSET;
						end else if (srch_i >= HEADER_SEARCH_WINDOW - 16'd1) begin
							phase_n = PH_DONE;
						end
					end
				end
				PH_OFFSET: begin
					if (pos_c == 16'(hdr_c) + 16'd7) begin
						if (off < 32'd8 || 34'(start_w) + 34'd2 > 34'(len_c)) begin
							phase_n = PH_DONE;
						end else begin
							ifd_n   = start_w[16:0];
							phase_n = PH_COUNT;
						end
					end
				end
				PH_COUNT: begin
					if (18'(pos_c) == 18'(ifd_c) + 18'd1) begin
						if (21'(ifd_c) + 21'd2 + 21'(n12) > 21'(len_c) || cnt_n == 16'd0) begin
							phase_n = PH_DONE;
						end else begin
							tags_n  = cnt_n;
							eo_n    = '0;
							ef_n    = '0;
							phase_n = PH_ENTRY;
						end
					end
				end
				PH_ENTRY: begin
					if (eo_c == 4'd1 && tag_c == ORIENT_TAG) begin
						ef_n    = '0;
						phase_n = PH_ORIENT;
					end
					if (eo_inc >= ENTRY_BYTES) begin
						eo_n   = '0;
						tags_n = tags_dec;
						if (tags_dec == 16'd0) begin
							phase_n = PH_DONE;
						end
					end else begin
						eo_n = eo_inc;
					end
				end
				PH_ORIENT: begin
					ef_n = full[55:0];
					if (eo_c >= ORIENT_LAST_OFFSET) begin
						sres_n  = (typ == SHORT_TYPE && cnt32 == 32'd1 && val <= MAX_ORIENT) ?
						          val[3:0] : 4'd0;
						phase_n = PH_DONE;
					end else begin
						eo_n = eo_inc;
					end
				end
				default: begin
				end
			endcase
		end

		pos_n  = (pos_c != POS_MAX) ? pos_c + 16'd1 : pos_c;
		exif   = (phase_n >= PH_SEARCH) && (phase_n <= PH_DONE);
		held_n = (item_s1.last_byte && exif) ? sres_n : held_c;
		if (item_s1.last_byte) begin
			phase_n = PH_IDLE;
		end
	end

	assign produces  = open_c && item_s1.last_byte;
	assign take      = item_valid_s1 && (!produces || slot_free);
	assign res_valid = take && produces;
	assign res       = '{orientation: held_n, segment_was_exif: exif};
	assign upd       = take && open_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
			win_q   <= '0;
			be_q    <= 1'b0;
			hdr_q   <= '0;
			ifd_q   <= '0;
			tags_q  <= '0;
			eo_q    <= '0;
			ef_q    <= '0;
			sres_q  <= '0;
			held_q  <= '0;
		end else if (upd) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			len_q   <= len_c;
			win_q   <= win_n;
			be_q    <= be_n;
			hdr_q   <= hdr_n;
			ifd_q   <= ifd_n;
			tags_q  <= tags_n;
			eo_q    <= eo_n;
			ef_q    <= ef_n;
			sres_q  <= sres_n;
			held_q  <= held_n;
		end
	end

endmodule

[rtl/core/exifo_out_stage.sv]
// ----------------------------------------------------------------------------
// exifo_out_stage
// Result register in front of the output channel.
// ----------------------------------------------------------------------------
module exifo_out_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_valid,
	input  exifo_pkg::exifo_result_t res,
	output logic                     slot_free,
	exifo_out_if.source              result
);
	import exifo_pkg::*;

	logic          valid_q;
	exifo_result_t res_q;

	assign slot_free               = !valid_q || result.ready;
	assign result.valid            = valid_q;
	assign result.orientation      = res_q.orientation;
	assign result.segment_was_exif = res_q.segment_was_exif;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

[rtl/core/exif_orientation_parser_top.sv]
// ----------------------------------------------------------------------------
// exif_orientation_parser_top
// Scans JPEG marker segment payloads for the Exif orientation tag.
//
//   channel  dir  word                          when
//   bytes    in   one payload byte + flags      every byte of a segment
//   result   out  orientation, segment_was_exif last byte of an open segment
//
// One byte per cycle sustained unless a held result stalls; a result word
// is registered in the result register once the parser takes the last byte.
// The parse state advances once per byte in a single pass between the
// input register and the result register.
// A held result stalls only a byte that ends a segment; one byte may wait
// in the input register meanwhile.
// arst_n clears all control state and the held orientation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module exif_orientation_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	exifo_in_if.sink     bytes,
	exifo_out_if.source  result
);
	import exifo_pkg::*;

	logic          take, item_valid_s1, slot_free, res_valid;
	exifo_item_t   item_s1;
	exifo_result_t res;

	exifo_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.bytes         (bytes),
		.take          (take),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	exifo_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.slot_free     (slot_free),
		.take          (take),
		.res_valid     (res_valid),
		.res           (res)
	);

	exifo_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free),
		.result    (result)
	);

	`ASSERT_IMPLIES(a_no_overwrite, res_valid, !result.valid || result.ready, "result overwritten")
	`ASSERT_IMPLIES(a_stall_cause, !bytes.ready, item_valid_s1 && result.valid && !result.ready, "stall without backpressure")
	`ASSERT_NEXT(a_orient_range, res_valid, result.valid && result.orientation <= 4'd8, "orientation out of range")

endmodule
